/* sv/ioskg_pkg.sv */
// Shared types and constants of the shuffle key generator.
// Used by ioskg_ctrl, ioskg_dp and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ioskg_pkg;

   // Fixed field widths
   localparam int RAND_W    = 31;
   localparam int ROW_W     = 33;
   localparam int KEY_W     = 32;
   localparam int COL_W     = 3;
   localparam int CLEN_W    = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   // Register indexes of the write port
   localparam logic [CSR_IDX_W-1:0] REG_ROW_OFFSET   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CYCLE_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_MODULUS  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_JOIN_COLUMN  = 2'd3;

   // Register reset values
   localparam logic [CLEN_W-1:0] CYCLE_LENGTH_RESET = 11'd1024;
   localparam logic [KEY_W-1:0]  KEY_MODULUS_RESET  = 32'd1;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;      // latch the step inputs
      logic start_cur;   // compute the scaling divisor for the current step
      logic start_main;  // launch scaling, modulo and next-step divisor
      logic read;        // read the key store at j
      logic emit_copy;   // load the copy write into the output register
      logic emit_final;  // load the final write and advance the step counter
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic hit;         // cached divisor belongs to the current step
      logic busy;        // a divider is still iterating
      logic need_copy;   // j differs from i
      logic out_free;    // output register can take a result this cycle
   } sts_type;

endpackage

`default_nettype wire

/* sv/ioskg_div.sv */
// Restoring serial divider: one quotient bit per cycle, W quotient bits per division.
// Depends on nothing; instantiated by ioskg_dp.
`timescale 1ns / 1ps
`default_nettype none

module ioskg_div #(
   parameter int W = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              busy,
   output logic              done,
   output logic [W-1:0]      quotient,
   output logic [W-1:0]      remainder
);

   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    shifted;
   logic [W:0]    diff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = shifted - {1'b0, den_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // keep the trial difference when it did not go negative
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

/* sv/ioskg_ctrl.sv */
// Step sequencer of the shuffle key generator.
// Depends on ioskg_pkg; drives the commands of ioskg_dp from its status.
`timescale 1ns / 1ps
`default_nettype none

module ioskg_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ioskg_pkg::sts_type sts,
   output ioskg_pkg::cmd_type     cmd
);

   import ioskg_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_CUR   = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_COPY  = 3'd5;
   localparam logic [2:0] ST_FINAL = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_PREP;
            end
         end
         ST_PREP: begin
            // launch the step only with a divisor that belongs to it
            if (sts.hit) begin
               cmd.start_main = 1'b1;
               state_in       = ST_DIV;
            end else begin
               cmd.start_cur = 1'b1;
               state_in      = ST_CUR;
            end
         end
         ST_CUR: begin
            if (!sts.busy) begin
               state_in = ST_PREP;
            end
         end
         ST_DIV: begin
            if (!sts.busy) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_COPY;
         end
         ST_COPY: begin
            if (!sts.need_copy) begin
               state_in = ST_FINAL;
            end else if (sts.out_free) begin
               cmd.emit_copy = 1'b1;
               state_in      = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (sts.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* sv/ioskg_dp.sv */
// Datapath of the shuffle key generator: registers, step counter, dividers,
// key store and output register. Depends on ioskg_pkg and ioskg_div.
`timescale 1ns / 1ps
`default_nettype none

module ioskg_dp #(
   parameter int          TABLE_DEPTH = 1024,
   parameter int unsigned RANDOM_MAX  = 2147483647
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire ioskg_pkg::cmd_type                  cmd,
   output ioskg_pkg::sts_type                       sts,
   input  wire logic                                csr_we,
   input  wire logic [ioskg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ioskg_pkg::CSR_DAT_W-1:0]     csr_wdata,
   input  wire logic [ioskg_pkg::RAND_W-1:0]        req_random_word,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [ioskg_pkg::ROW_W-1:0]              rsp_row_address,
   output logic [ioskg_pkg::KEY_W-1:0]              rsp_key_value,
   output logic [ioskg_pkg::COL_W-1:0]              rsp_column,
   output logic                                     rsp_last_of_step,
   output logic                                     rsp_run_done
);

   import ioskg_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int LW = $clog2(TABLE_DEPTH + 1);
   localparam int DW = 32;

   // configuration registers
   logic [KEY_W-1:0]  row_offset_ff;
   logic [CLEN_W-1:0] cycle_length_ff;
   logic [KEY_W-1:0]  key_modulus_ff;
   logic [COL_W-1:0]  join_column_ff;

   // step state and latched step inputs
   logic [AW-1:0]     step_ff;
   logic [RAND_W-1:0] rand_ff;
   logic [AW-1:0]     i_ff;
   logic [AW-1:0]     nxt_ff;
   logic              wrap_ff;
   logic [ROW_W-1:0]  sum_ff;

   // cached scaling divisor and the step index it belongs to
   logic [DW-1:0]     pre_div_ff;
   logic [AW-1:0]     pre_idx_ff;
   logic [AW-1:0]     pre_arg_ff;
   logic              pre_ok_ff;

   logic [KEY_W-1:0]  rd_data_ff;
   logic [KEY_W-1:0]  key_store [TABLE_DEPTH];

   // output register
   logic              rsp_valid_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [COL_W-1:0]  col_ff;
   logic              last_ff;
   logic              done_ff;

   logic [LW-1:0]     len;
   logic [AW-1:0]     i_cur;
   logic [LW-1:0]     i_plus;
   logic              wrap_cur;
   logic [AW-1:0]     nxt_cur;

   logic              pre_start;
   logic [AW-1:0]     pre_arg;
   logic              pre_busy, pre_done, quo_busy, mod_busy;
   logic [DW-1:0]     pre_q, quo_q;
   logic [ROW_W-1:0]  mod_r;

   logic [AW-1:0]     j_idx;
   logic [KEY_W-1:0]  gen_key;
   logic              st_we;
   logic [AW-1:0]     st_waddr;
   logic [KEY_W-1:0]  st_wdata;

   // effective cycle length and the step indexes derived from it
   always_comb begin
      if (cycle_length_ff == '0) begin
         len = LW'(1);
      end else if (32'(cycle_length_ff) > 32'(TABLE_DEPTH)) begin
         len = LW'(TABLE_DEPTH);
      end else begin
         len = LW'(cycle_length_ff);
      end
      i_cur    = (LW'(step_ff) >= len) ? '0 : step_ff;
      i_plus   = LW'(i_cur) + LW'(1);
      wrap_cur = (i_plus >= len);
      nxt_cur  = wrap_cur ? '0 : AW'(i_plus);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_offset_ff   <= '0;
         cycle_length_ff <= CYCLE_LENGTH_RESET;
         key_modulus_ff  <= KEY_MODULUS_RESET;
         join_column_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_ROW_OFFSET:   row_offset_ff   <= csr_wdata;
            REG_CYCLE_LENGTH: cycle_length_ff <= csr_wdata[CLEN_W-1:0];
            REG_KEY_MODULUS:  key_modulus_ff  <= csr_wdata;
            REG_JOIN_COLUMN:  join_column_ff  <= csr_wdata[COL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rand_ff <= req_random_word;
         i_ff    <= i_cur;
         nxt_ff  <= nxt_cur;
         wrap_ff <= wrap_cur;
         sum_ff  <= {1'b0, row_offset_ff} + ROW_W'(i_cur);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.emit_final) begin
         step_ff <= nxt_ff;
      end
   end

   // divisor unit: current step on a miss, next step during the main division
   assign pre_start = cmd.start_cur | cmd.start_main;
   assign pre_arg   = cmd.start_cur ? i_ff : nxt_ff;

   ioskg_div #(.W(DW)) u_pre (
      .clock     (clock),
      .reset     (reset),
      .start     (pre_start),
      .dividend  (DW'(RANDOM_MAX)),
      .divisor   (DW'(pre_arg) + DW'(1)),
      .busy      (pre_busy),
      .done      (pre_done),
      .quotient  (pre_q),
      .remainder ()
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ok_ff <= 1'b0;
      end else if (pre_start) begin
         pre_ok_ff <= 1'b0;
      end else if (pre_done) begin
         pre_ok_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pre_start) begin
         pre_arg_ff <= pre_arg;
      end
      if (pre_done) begin
         pre_div_ff <= pre_q + DW'(1);
         pre_idx_ff <= pre_arg_ff;
      end
   end

   // scale the random word to j
   ioskg_div #(.W(DW)) u_quo (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start_main),
      .dividend  (DW'(rand_ff)),
      .divisor   (pre_div_ff),
      .busy      (quo_busy),
      .done      (),
      .quotient  (quo_q),
      .remainder ()
   );

   // generated key: (row_offset + i) mod key_modulus
   ioskg_div #(.W(ROW_W)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start_main),
      .dividend  (sum_ff),
      .divisor   ({1'b0, key_modulus_ff}),
      .busy      (mod_busy),
      .done      (),
      .quotient  (),
      .remainder (mod_r)
   );

   // saturate j to i for words above the random range
   assign j_idx   = (quo_q > DW'(i_ff)) ? i_ff : quo_q[AW-1:0];
   assign gen_key = (key_modulus_ff == '0) ? sum_ff[KEY_W-1:0] : mod_r[KEY_W-1:0];

   // key store: copy write goes to i, final write to j
   always_comb begin
      st_we    = cmd.emit_copy | cmd.emit_final;
      st_waddr = cmd.emit_copy ? i_ff : j_idx;
      st_wdata = cmd.emit_copy ? rd_data_ff : gen_key;
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         key_store[st_waddr] <= st_wdata;
      end
      if (cmd.read) begin
         rd_data_ff <= key_store[j_idx];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_copy | cmd.emit_final) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_copy) begin
         row_ff  <= sum_ff;
         key_ff  <= rd_data_ff;
         col_ff  <= join_column_ff;
         last_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (cmd.emit_final) begin
         row_ff  <= {1'b0, row_offset_ff} + ROW_W'(j_idx);
         key_ff  <= gen_key;
         col_ff  <= join_column_ff;
         last_ff <= 1'b1;
         done_ff <= wrap_ff;
      end
   end

   always_comb begin
      sts.hit       = pre_ok_ff && (pre_idx_ff == i_ff);
      sts.busy      = pre_busy | quo_busy | mod_busy;
      sts.need_copy = (j_idx != i_ff);
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_row_address  = row_ff;
   assign rsp_key_value    = key_ff;
   assign rsp_column       = col_ff;
   assign rsp_last_of_step = last_ff;
   assign rsp_run_done     = done_ff;

   a_accept_idle : assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> !sts.busy)
      else $error("item taken while a divider is still iterating");

   a_read_settled : assert property (@(posedge clock) disable iff (reset)
      cmd.read |-> !sts.busy)
      else $error("key store read before the divisions settled");

   a_main_divisor : assert property (@(posedge clock) disable iff (reset)
      cmd.start_main |-> pre_ok_ff && pre_idx_ff == i_ff)
      else $error("scaling started with a divisor of another step");

   a_j_range : assert property (@(posedge clock) disable iff (reset)
      cmd.emit_final |-> j_idx <= i_ff)
      else $error("scaled index above the step index");

endmodule

`default_nettype wire

/* sv/inside_out_shuffle_key_generator_core.sv */
// Top level of the inside-out shuffle key generator.
// Depends on ioskg_pkg, ioskg_ctrl, ioskg_dp (and ioskg_div below it).
//
//   channel   ports                               direction  one transfer
//   req       req_valid/req_ready                 in         one random word = one step
//   rsp       rsp_valid/rsp_ready                 out        one row write (1 or 2 per step)
//   csr       csr_we/csr_index/csr_wdata          in         one register write, no wait
//
// A step runs from transfer to final write while the remainder division
// (row_offset + i) mod key_modulus sets its length, with the scaling
// division of the random word running beside it; the next req transfer can
// follow once the final write is loaded into the output register. The
// scaling divisor for the next step is computed during the current one; when
// it does not match (first step after reset or after a cycle_length change)
// the divisor for the current step is computed first.
// Reset is synchronous and active high; the key store is not cleared.
// A stalled rsp side holds the sequencer before each write; a waiting final
// write does not block the next req transfer.
`timescale 1ns / 1ps
`default_nettype none

module inside_out_shuffle_key_generator_core #(
   parameter int          TABLE_DEPTH = 1024,
   parameter int unsigned RANDOM_MAX  = 2147483647
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // random word input
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [ioskg_pkg::RAND_W-1:0]    req_random_word,
   // row write output
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [ioskg_pkg::ROW_W-1:0]          rsp_row_address,
   output logic [ioskg_pkg::KEY_W-1:0]          rsp_key_value,
   output logic [ioskg_pkg::COL_W-1:0]          rsp_column,
   output logic                                 rsp_last_of_step,
   output logic                                 rsp_run_done,
   // register write port
   input  wire logic                            csr_we,
   input  wire logic [ioskg_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ioskg_pkg::CSR_DAT_W-1:0] csr_wdata
);

   import ioskg_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer: accept, divide, read the store, emit copy and final writes
   ioskg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // registers, dividers, key store and output register
   ioskg_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .RANDOM_MAX  (RANDOM_MAX)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_random_word  (req_random_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_row_address  (rsp_row_address),
      .rsp_key_value    (rsp_key_value),
      .rsp_column       (rsp_column),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_run_done     (rsp_run_done)
   );

endmodule

`default_nettype wire

/* bench/inside_out_shuffle_key_generator_core_tb.sv */
// Self-checking bench for inside_out_shuffle_key_generator_core: directed steps,
// a stalled-output phase and randomized register settings, checked per row write.
// Depends on ioskg_pkg and the core with its submodules.
`timescale 1ns / 1ps

module inside_out_shuffle_key_generator_core_tb;

   import ioskg_pkg::*;

   localparam int          STORE_DEPTH = 1024;
   localparam int unsigned WORD_MAX    = 2147483647;
   localparam int          IDLE_PAUSE  = 100;          // cycles of quiet before a register write
   localparam longint      LIMIT_NS    = 64'd10_000_000; // run time limit of the watchdog

   // One row write as seen on the rsp channel
   typedef struct packed {
      logic [ROW_W-1:0] row_address;
      logic [KEY_W-1:0] key_value;
      logic [COL_W-1:0] column;
      logic             last_of_step;
      logic             run_done;
   } row_write_type;

   // Receiver behavior between forced hold-offs
   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [RAND_W-1:0]    req_random_word = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [ROW_W-1:0]     rsp_row_address;
   logic [KEY_W-1:0]     rsp_key_value;
   logic [COL_W-1:0]     rsp_column;
   logic                 rsp_last_of_step;
   logic                 rsp_run_done;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // Mirror of the block's registers and shuffle state
   logic [KEY_W-1:0]  cfg_row_offset   = '0;
   logic [CLEN_W-1:0] cfg_cycle_length = CYCLE_LENGTH_RESET;
   logic [KEY_W-1:0]  cfg_key_modulus  = KEY_MODULUS_RESET;
   logic [COL_W-1:0]  cfg_join_column  = '0;
   int unsigned       shuffle_index    = 0;
   logic [KEY_W-1:0]  key_mirror [0:STORE_DEPTH-1];

   row_write_type pending_writes [$];

   // Sender burst shaping and receiver hold-off request
   int burst_left   = 0;
   bit no_gaps      = 1'b0;
   int hold_request = 0;

   // Run statistics
   int fail_count     = 0;
   int steps_sent     = 0;
   int writes_checked = 0;
   int copy_writes    = 0;
   int cycles_done    = 0;
   int setting_phases = 0;

   inside_out_shuffle_key_generator_core #(
      .TABLE_DEPTH (STORE_DEPTH),
      .RANDOM_MAX  (WORD_MAX)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_random_word  (req_random_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_row_address  (rsp_row_address),
      .rsp_key_value    (rsp_key_value),
      .rsp_column       (rsp_column),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_run_done     (rsp_run_done),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      for (int k = 0; k < STORE_DEPTH; k++) key_mirror[k] = '0;
   end

   // Advance the shuffle by one step and queue the row writes it causes:
   // an optional copy write, then the final write of the new key.
   task automatic shuffle_step(input logic [RAND_W-1:0] word);
      longint unsigned len, i, divisor, j, sum, key;
      logic [KEY_W-1:0] copied;
      logic             done;
      row_write_type    w;
      len = 64'(cfg_cycle_length);
      if (len == 0) len = 1;
      if (len > STORE_DEPTH) len = STORE_DEPTH;
      i = 64'(shuffle_index);
      // counter left beyond a shortened cycle: restart at step 0
      if (i >= len) i = 0;
      divisor = longint'(WORD_MAX) / (i + 1) + 1;
      j = longint'(word) / divisor;
      if (j > i) j = i;
      sum = longint'(cfg_row_offset) + i;
      // a zero modulus means 2^32: keep the low 32 bits
      if (cfg_key_modulus == 0) key = sum & 64'hFFFF_FFFF;
      else key = sum % longint'(cfg_key_modulus);
      if (j != i) begin
         copied = key_mirror[j];
         key_mirror[i] = copied;
         w.row_address  = sum[ROW_W-1:0];
         w.key_value    = copied;
         w.column       = cfg_join_column;
         w.last_of_step = 1'b0;
         w.run_done     = 1'b0;
         pending_writes.push_back(w);
         copy_writes++;
      end
      key_mirror[j] = key[KEY_W-1:0];
      done = (i + 1 >= len);
      w.row_address  = ROW_W'(longint'(cfg_row_offset) + j);
      w.key_value    = key[KEY_W-1:0];
      w.column       = cfg_join_column;
      w.last_of_step = 1'b1;
      w.run_done     = done;
      pending_writes.push_back(w);
      if (done) cycles_done++;
      shuffle_index = done ? 0 : int'(i + 1);
   endtask

   // Offer one random word and hold it until the transfer; end the burst with
   // a random gap unless gaps are switched off.
   task automatic send_word(input logic [RAND_W-1:0] word);
      int gap;
      req_valid       <= 1'b1;
      req_random_word <= word;
      do @(posedge clock); while (!req_ready);
      shuffle_step(word);
      steps_sent++;
      if (no_gaps || burst_left > 0) begin
         if (burst_left > 0) burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(0, 40);
      end
   endtask

   // Drop valid, wait for every queued write, then let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (IDLE_PAUSE) @(posedge clock);
   endtask

   // One register write; update the mirror with the same masking as the block
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_ROW_OFFSET:   cfg_row_offset   = data;
         REG_CYCLE_LENGTH: cfg_cycle_length = data[CLEN_W-1:0];
         REG_KEY_MODULUS:  cfg_key_modulus  = data;
         REG_JOIN_COLUMN:  cfg_join_column  = data[COL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [CSR_DAT_W-1:0] offset, input logic [CSR_DAT_W-1:0] length,
                            input logic [CSR_DAT_W-1:0] modulus, input logic [CSR_DAT_W-1:0] col);
      write_reg(REG_ROW_OFFSET, offset);
      write_reg(REG_CYCLE_LENGTH, length);
      write_reg(REG_KEY_MODULUS, modulus);
      write_reg(REG_JOIN_COLUMN, col);
      setting_phases++;
   endtask

   // Reset values: full-size cycle, modulus 1 so every key is zero
   task automatic test_reset_defaults();
      setting_phases++;
      send_word('0);
      send_word(RAND_W'(WORD_MAX));
      send_word(31'h4000_0000);
      send_word(31'h2AAA_AAAA);
      settle();
   endtask

   // Register extremes and the corner cases of length, counter and modulus
   task automatic test_special_settings();
      // length 3 while the counter sits at 4: that step restarts at 0;
      // top offset pushes the row address into bit 32, zero modulus wraps keys
      write_all(32'hFFFF_FFFF, 32'd3, 32'd0, 32'd7);
      send_word(RAND_W'(WORD_MAX));
      send_word('0);
      send_word(RAND_W'(WORD_MAX));
      send_word(31'h5555_5555);
      send_word('0);
      send_word(RAND_W'(WORD_MAX));
      settle();
      // length 0 acts as 1: every step ends a cycle
      write_all(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
      send_word(RAND_W'(WORD_MAX));
      send_word('0);
      send_word(31'h7FFF_0000);
      settle();
      // length above the store depth is clamped to it
      write_all(32'd123456, 32'd2047, 32'd5, 32'd5);
      send_word(RAND_W'(WORD_MAX));
      send_word('0);
      send_word(RAND_W'(WORD_MAX));
      send_word(31'h3FFF_FFFF);
      send_word(31'h0000_0001);
      send_word(31'h7FFF_FFFE);
      settle();
   endtask

   // Hold the result side off while words keep coming, so the core backs up
   task automatic test_output_backpressure();
      write_all($urandom(), 32'd8, 32'd1000, 32'd2);
      no_gaps      = 1'b1;
      hold_request = 400;
      repeat (30) send_word(RAND_W'($urandom()));
      no_gaps = 1'b0;
      settle();
   endtask

   // Random register settings, mostly short cycles so run_done comes often
   task automatic test_random_settings();
      logic [CSR_DAT_W-1:0] offset, length, modulus, col;
      logic [RAND_W-1:0]    word;
      for (int p = 0; p < 14; p++) begin
         case ($urandom_range(0, 3))
            0: offset = 32'd0;
            1: offset = 32'hFFFF_FFFF - $urandom_range(0, 64);
            default: offset = $urandom();
         endcase
         case ($urandom_range(0, 9))
            6: length = 32'd1024;
            7: length = $urandom_range(1025, 2047);
            8: length = 32'd0;
            9: length = $urandom_range(25, 300);
            default: length = $urandom_range(1, 24);
         endcase
         // junk above the register width must be dropped
         if ($urandom_range(0, 1) == 0) length = length | ($urandom() & 32'hFFFF_F800);
         case ($urandom_range(0, 5))
            0: modulus = 32'd0;
            1: modulus = 32'hFFFF_FFFF;
            2: modulus = 32'd1;
            3: modulus = $urandom_range(2, 16);
            default: modulus = $urandom();
         endcase
         col = $urandom_range(0, 7);
         if ($urandom_range(0, 1) == 0) col = col | ($urandom() & 32'hFFFF_FFF8);
         write_all(offset, length, modulus, col);
         for (int n = 0; n < 50; n++) begin
            case ($urandom_range(0, 9))
               0: word = ($urandom_range(0, 1) == 0) ? '0 : RAND_W'(WORD_MAX);
               1: word = RAND_W'($urandom_range(0, 4096));
               default: word = RAND_W'($urandom());
            endcase
            send_word(word);
         end
         settle();
      end
   endtask

   // Receiver: pick a stall mode for a random stretch; a hold-off request
   // forces ready low for that many cycles first.
   initial begin : rsp_stall_pattern
      int             hold_left;
      int             stretch_left;
      stall_mode_type mode;
      hold_left    = 0;
      stretch_left = 0;
      mode         = STALL_NONE;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (stretch_left == 0) begin
            mode         = stall_mode_type'($urandom_range(0, 3));
            stretch_left = $urandom_range(16, 96);
         end
         stretch_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               STALL_NONE:   rsp_ready <= 1'b1;
               STALL_LIGHT:  rsp_ready <= ($urandom_range(0, 3) != 0);
               STALL_HEAVY:  rsp_ready <= ($urandom_range(0, 3) == 0);
               default:      rsp_ready <= ~rsp_ready;
            endcase
         end
      end
   end

   // Compare every transfer on the rsp side with the oldest queued write
   always @(posedge clock) begin : rsp_checker
      row_write_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_writes.size() == 0) begin
            $error("unexpected row write: row_address %0h key_value %0h",
                   rsp_row_address, rsp_key_value);
            fail_count++;
         end else begin
            want = pending_writes.pop_front();
            writes_checked++;
            if (rsp_row_address !== want.row_address) begin
               $error("row_address mismatch: expected %0h, got %0h",
                      want.row_address, rsp_row_address);
               fail_count++;
            end
            if (rsp_key_value !== want.key_value) begin
               $error("key_value mismatch: expected %0h, got %0h",
                      want.key_value, rsp_key_value);
               fail_count++;
            end
            if (rsp_column !== want.column) begin
               $error("column mismatch: expected %0d, got %0d", want.column, rsp_column);
               fail_count++;
            end
            if (rsp_last_of_step !== want.last_of_step) begin
               $error("last_of_step mismatch: expected %0b, got %0b",
                      want.last_of_step, rsp_last_of_step);
               fail_count++;
            end
            if (rsp_run_done !== want.run_done) begin
               $error("run_done mismatch: expected %0b, got %0b", want.run_done, rsp_run_done);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure
   initial begin
      #(LIMIT_NS);
      $display("inside_out_shuffle_key_generator_core test failed");
      $finish;
   end

   initial begin
      // Hold reset, then release it on a rising edge
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_special_settings();
      test_output_backpressure();
      test_random_settings();
      $display("Covered %0d shuffle steps over %0d register settings: %0d row writes checked,",
               steps_sent, setting_phases, writes_checked);
      $display("  %0d of them copy writes, %0d shuffle cycles completed.",
               copy_writes, cycles_done);
      if (fail_count == 0) begin
         $display("inside_out_shuffle_key_generator_core test passed");
      end else begin
         $display("inside_out_shuffle_key_generator_core test failed");
      end
      $finish;
   end

endmodule
